/* hdl/tv_denoise_gradient_step_core_assert.svh */
// Assertion macros for the verification files of the TV denoise core.
// Depends on nothing; included by the port checker.
`ifndef TV_DENOISE_GRADIENT_STEP_CORE_ASSERT_SVH
`define TV_DENOISE_GRADIENT_STEP_CORE_ASSERT_SVH
// Same-cycle implication, disabled while reset is asserted.
`define TVD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define TVD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* hdl/tvd_pkg.sv */
// Shared constants, register indexes and the controller command type of the
// TV denoise gradient step core. Depends on nothing.
package tvd_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int MAX_HEIGHT = 4096;
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int PIX_W      = 16;
	localparam int GRAD_W     = 24;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int WREG_W     = 11;
	localparam int HREG_W     = 13;

	localparam logic [CFG_IDX_W-1:0] REG_LAMBDA = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;

	typedef struct packed {
		logic             wr;
		logic [1:0]       wr_row;
		logic [COL_W-1:0] wr_col;
		logic             rd;
		logic [1:0]       rd_row;
		logic [COL_W-1:0] rd_col;
		logic             obs_rd;
		logic             obs_row;
		logic [COL_W-1:0] obs_col;
		logic             win_cap;
		logic [3:0]       win_idx;
		logic             obs_cap;
		logic [1:0]       term;
		logic             norm_start;
		logic             acc_clr;
		logic             acc;
		logic             grad1;
		logic             grad2;
		logic             upd1;
		logic             upd2;
		logic             out_load;
	} tvd_cmd_t;

endpackage

/* hdl/tvd_norm.sv */
// Normalising unit: a / sqrt(a^2 + b^2 + beta) by bit-serial root and division.
// Depends on nothing; stands alone.
module tvd_norm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [17:0] a,
	input  logic signed [16:0] b,
	input  logic [15:0]        beta,
	output logic               done,
	output logic signed [17:0] v
);

	typedef enum logic [2:0] {N_IDLE, N_SQA, N_SQB, N_ROOT, N_DIV, N_DONE} nstate_t;

	nstate_t            state_q;
	logic [4:0]         cnt_q;
	logic signed [17:0] a_q;
	logic signed [16:0] b_q;
	logic [17:0]        mag_q;
	logic               neg_q;
	logic [34:0]        sq_q;
	logic [47:0]        v_q;
	logic [47:0]        res_q;
	logic [47:0]        bit_q;
	logic [23:0]        rem_q;
	logic [17:0]        quo_q;
	logic signed [17:0] out_q;

	logic signed [35:0] asq;
	logic signed [33:0] bsq;
	logic [47:0]        trial;
	logic [24:0]        r2;

	function automatic logic [17:0] qh_next(input logic [17:0] q, input logic [24:0] rr,
	                                        input logic [23:0] den);
		logic [17:0] qn;
		qn = {q[16:0], (rr >= {1'b0, den})};
		return (qn + 18'd1) >> 1;
	endfunction

	assign asq   = a_q * a_q;
	assign bsq   = b_q * b_q;
	assign trial = res_q + bit_q;
	assign r2    = {rem_q, 1'b0};
	assign done  = (state_q == N_DONE);
	assign v     = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				N_IDLE: begin
					if (start) begin
						a_q     <= a;
						b_q     <= b;
						neg_q   <= a[17];
						mag_q   <= a[17] ? 18'(-a) : 18'(a);
						state_q <= N_SQA;
					end
				end
				N_SQA: begin
					sq_q    <= asq[34:0];
					state_q <= N_SQB;
				end
				N_SQB: begin
					v_q     <= {1'b0, sq_q + {3'b0, bsq[31:0]} + {9'b0, beta, 10'b0}, 12'b0};
					res_q   <= '0;
					bit_q   <= 48'h4000_0000_0000;
					cnt_q   <= 5'd23;
					state_q <= N_ROOT;
				end
				N_ROOT: begin
					if (v_q >= trial) begin
						v_q   <= v_q - trial;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (cnt_q == '0) begin
						cnt_q   <= 5'd17;
						rem_q   <= {1'b0, mag_q, 5'b0};
						quo_q   <= '0;
						state_q <= N_DIV;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				N_DIV: begin
					if (r2 >= {1'b0, res_q[23:0]}) begin
						rem_q <= 24'(r2 - {1'b0, res_q[23:0]});
						quo_q <= {quo_q[16:0], 1'b1};
					end else begin
						rem_q <= r2[23:0];
						quo_q <= {quo_q[16:0], 1'b0};
					end
					if (cnt_q == '0) begin
						state_q <= N_DONE;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				N_DONE: begin
					state_q <= N_IDLE;
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	// The result is formed as the division finishes and held while done is high.
	always_ff @(posedge clk) begin
		if (state_q == N_DIV && cnt_q == '0) begin
			if (res_q[23:0] == '0) begin
				out_q <= '0;
			end else begin
				out_q <= neg_q ? -$signed(qh_next(quo_q, r2, res_q[23:0]))
				               : $signed(qh_next(quo_q, r2, res_q[23:0]));
			end
		end
	end

endmodule

/* hdl/tvd_datapath.sv */
// Datapath of the TV denoise core: line memories, 3x3 window, term selection,
// accumulation and output arithmetic. Depends on tvd_pkg and tvd_norm.
module tvd_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tvd_pkg::tvd_cmd_t      cmd,
	input  logic signed [15:0]     in_estimate,
	input  logic signed [15:0]     in_observed,
	input  logic [15:0]            lambda,
	input  logic [15:0]            step_size,
	input  logic [15:0]            smoothing,
	output logic                   norm_done,
	output logic [39:0]            out_data
);

	logic signed [15:0] est_mem [4*tvd_pkg::MAX_WIDTH];
	logic signed [15:0] obs_mem [2*tvd_pkg::MAX_WIDTH];
	logic signed [15:0] est_rd_q, obs_rd_q, obs_q;
	logic signed [15:0] win_q [9];
	logic signed [19:0] div_q;
	logic signed [33:0] prod_q;
	logic signed [23:0] grad_q;
	logic signed [40:0] prod2_q;
	logic signed [15:0] upd_q;
	logic [39:0]        out_q;

	logic signed [15:0] p;
	logic signed [16:0] ad;
	logic signed [17:0] term_a;
	logic signed [16:0] term_b;
	logic signed [17:0] norm_v;
	logic signed [35:0] g20;
	logic signed [35:0] g20r;
	logic signed [41:0] u;
	logic signed [41:0] ur;

	function automatic logic signed [16:0] dif(input logic signed [15:0] x,
	                                           input logic signed [15:0] y);
		return $signed({x[15], x}) - $signed({y[15], y});
	endfunction

	function automatic logic signed [16:0] minmod(input logic signed [16:0] x,
	                                              input logic signed [16:0] y);
		logic signed [16:0] mx, my, mn;
		mx = x[16] ? -x : x;
		my = y[16] ? -y : y;
		mn = (mx <= my) ? mx : my;
		if (x > 0 && y > 0) return mn;
		if (x < 0 && y < 0) return -mn;
		return '0;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			est_mem[{cmd.wr_row, cmd.wr_col}] <= in_estimate;
			obs_mem[{cmd.wr_row[0], cmd.wr_col}] <= in_observed;
		end
		if (cmd.rd) est_rd_q <= est_mem[{cmd.rd_row, cmd.rd_col}];
		if (cmd.obs_rd) obs_rd_q <= obs_mem[{cmd.obs_row, cmd.obs_col}];
	end

	assign p = win_q[4];

	always_comb begin
		unique case (cmd.term)
			2'd0: begin
				ad     = dif(win_q[7], p);
				term_b = minmod(dif(win_q[8], win_q[6]), dif(win_q[5], win_q[3]));
			end
			2'd1: begin
				ad     = dif(p, win_q[1]);
				term_b = minmod(dif(win_q[5], win_q[3]), dif(win_q[2], win_q[0]));
			end
			2'd2: begin
				ad     = dif(win_q[5], p);
				term_b = minmod(dif(win_q[8], win_q[2]), dif(win_q[7], win_q[1]));
			end
			default: begin
				ad     = dif(p, win_q[3]);
				term_b = minmod(dif(win_q[7], win_q[1]), dif(win_q[6], win_q[0]));
			end
		endcase
	end

	assign term_a = $signed({ad, 1'b0});

	tvd_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.norm_start),
		.a      (term_a),
		.b      (term_b),
		.beta   (smoothing),
		.done   (norm_done),
		.v      (norm_v)
	);

	assign g20  = $signed({{2{prod_q[33]}}, prod_q}) - $signed({{12{div_q[19]}}, div_q, 4'b0});
	assign g20r = (g20 + 36'sd128) >>> 8;
	assign u    = $signed({{10{p[15]}}, p, 16'b0}) - $signed({prod2_q[40], prod2_q})
	            + 42'sd32768;
	assign ur   = u >>> 16;

	always_ff @(posedge clk) begin
		if (cmd.win_cap) win_q[cmd.win_idx] <= est_rd_q;
		if (cmd.obs_cap) obs_q <= obs_rd_q;
		if (cmd.acc_clr) begin
			div_q <= '0;
		end else if (cmd.acc) begin
			// Forward differences add, backward differences subtract.
			if (!cmd.term[0]) div_q <= div_q + $signed({{2{norm_v[17]}}, norm_v});
			else              div_q <= div_q - $signed({{2{norm_v[17]}}, norm_v});
		end
		if (cmd.grad1) prod_q <= $signed({1'b0, lambda}) * dif(p, obs_q);
		if (cmd.grad2) begin
			if (g20r > 36'sd8388607)       grad_q <= 24'sh7FFFFF;
			else if (g20r < -36'sd8388608) grad_q <= 24'sh800000;
			else                           grad_q <= g20r[23:0];
		end
		if (cmd.upd1) prod2_q <= $signed({1'b0, step_size}) * grad_q;
		if (cmd.upd2) begin
			if (ur > 42'sd32767)       upd_q <= 16'sh7FFF;
			else if (ur < -42'sd32768) upd_q <= 16'sh8000;
			else                       upd_q <= ur[15:0];
		end
		if (cmd.out_load) out_q <= {upd_q, grad_q};
	end

	assign out_data = out_q;

endmodule

/* hdl/tvd_ctrl.sv */
// Controller of the TV denoise core: frame position, window fetch sequence,
// term scheduling and output handshake. Depends on tvd_pkg.
module tvd_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      restart,
	input  logic [tvd_pkg::WREG_W-1:0] eff_w,
	input  logic [tvd_pkg::HREG_W-1:0] eff_h,
	input  logic                      in_valid,
	input  logic                      in_flush,
	output logic                      in_ready,
	input  logic                      norm_done,
	output logic                      out_valid,
	output logic                      out_last,
	input  logic                      out_ready,
	output tvd_pkg::tvd_cmd_t         cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_FETCH, S_TERM, S_NORM, S_GRAD1, S_GRAD2, S_UPD1, S_UPD2, S_OUT
	} state_t;

	state_t                      state_q;
	logic [tvd_pkg::HREG_W-1:0]  row_q;
	logic [tvd_pkg::WREG_W-1:0]  col_q;
	logic [tvd_pkg::ROW_W-1:0]   r_q;
	logic [tvd_pkg::COL_W-1:0]   c_q;
	logic                        last_q;
	logic [3:0]                  cnt_q;
	logic [1:0]                  term_q;
	logic                        out_valid_q;
	logic                        out_last_q;

	logic                        accept, in_frame, produce;
	logic [tvd_pkg::WREG_W-1:0]  col_n;
	logic [tvd_pkg::ROW_W-1:0]   lastr, r_n, rr;
	logic [tvd_pkg::COL_W-1:0]   lastc, c_n, cc;
	logic [1:0]                  rsel, csel;
	logic [3:0]                  term_en;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign in_frame  = (row_q < eff_h);
	assign produce   = (row_q >= 13'd2) || (row_q == 13'd1 && col_q != '0);
	assign col_n     = col_q + 11'd1;
	assign lastr     = 12'(eff_h - 13'd1);
	assign lastc     = 10'(eff_w - 11'd1);
	assign r_n       = 12'(row_q - ((col_q == '0) ? 13'd2 : 13'd1));
	assign c_n       = (col_q == '0) ? lastc : 10'(col_q - 11'd1);
	assign term_en   = {c_q != '0, c_q < lastc, r_q != '0, r_q < lastr};
	assign out_valid = out_valid_q;
	assign out_last  = out_last_q;

	always_comb begin
		unique case (cnt_q)
			4'd0:    begin rsel = 2'd0; csel = 2'd0; end
			4'd1:    begin rsel = 2'd0; csel = 2'd1; end
			4'd2:    begin rsel = 2'd0; csel = 2'd2; end
			4'd3:    begin rsel = 2'd1; csel = 2'd0; end
			4'd4:    begin rsel = 2'd1; csel = 2'd1; end
			4'd5:    begin rsel = 2'd1; csel = 2'd2; end
			4'd6:    begin rsel = 2'd2; csel = 2'd0; end
			4'd7:    begin rsel = 2'd2; csel = 2'd1; end
			default: begin rsel = 2'd2; csel = 2'd2; end
		endcase
		// Neighbours beyond the border repeat the edge pixel.
		unique case (rsel)
			2'd0:    rr = (r_q == '0) ? r_q : r_q - 12'd1;
			2'd1:    rr = r_q;
			default: rr = (r_q == lastr) ? r_q : r_q + 12'd1;
		endcase
		unique case (csel)
			2'd0:    cc = (c_q == '0) ? c_q : c_q - 10'd1;
			2'd1:    cc = c_q;
			default: cc = (c_q == lastc) ? c_q : c_q + 10'd1;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.wr         = accept && in_frame && !in_flush;
		cmd.wr_row     = row_q[1:0];
		cmd.wr_col     = col_q[tvd_pkg::COL_W-1:0];
		cmd.rd_row     = rr[1:0];
		cmd.rd_col     = cc;
		cmd.obs_row    = r_q[0];
		cmd.obs_col    = c_q;
		cmd.win_idx    = cnt_q - 4'd1;
		cmd.term       = term_q;
		unique case (state_q)
			S_FETCH: begin
				cmd.rd      = (cnt_q < 4'd9);
				cmd.win_cap = (cnt_q != '0);
				cmd.obs_rd  = (cnt_q == '0);
				cmd.obs_cap = (cnt_q == 4'd1);
				cmd.acc_clr = (cnt_q == '0);
			end
			S_TERM:  cmd.norm_start = term_en[term_q];
			S_NORM:  cmd.acc = norm_done;
			S_GRAD1: cmd.grad1 = 1'b1;
			S_GRAD2: cmd.grad2 = 1'b1;
			S_UPD1:  cmd.upd1 = 1'b1;
			S_UPD2:  cmd.upd2 = 1'b1;
			S_OUT:   cmd.out_load = !out_valid_q || out_ready;
			default: cmd.wr = accept && in_frame && !in_flush;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			r_q         <= '0;
			c_q         <= '0;
			last_q      <= 1'b0;
			cnt_q       <= '0;
			term_q      <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			// The frame-end flag travels with the result it belongs to.
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				out_last_q  <= last_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (restart) begin
						row_q <= '0;
						col_q <= '0;
					end else if (accept && !(in_frame && in_flush)) begin
						if (produce) begin
							r_q     <= r_n;
							c_q     <= c_n;
							last_q  <= (r_n == lastr) && (c_n == lastc);
							cnt_q   <= '0;
							state_q <= S_FETCH;
						end
						if (in_frame) begin
							if (col_n == eff_w) begin
								col_q <= '0;
								row_q <= row_q + 13'd1;
							end else begin
								col_q <= col_n;
							end
						end else if (col_n > eff_w) begin
							col_q <= '0;
							row_q <= '0;
						end else begin
							col_q <= col_n;
						end
					end
				end
				S_FETCH: begin
					if (cnt_q == 4'd9) begin
						term_q  <= '0;
						state_q <= S_TERM;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_TERM: begin
					if (term_en[term_q])   state_q <= S_NORM;
					else if (term_q == 2'd3) state_q <= S_GRAD1;
					else                   term_q <= term_q + 2'd1;
				end
				S_NORM: begin
					if (norm_done) begin
						if (term_q == 2'd3) begin
							state_q <= S_GRAD1;
						end else begin
							term_q  <= term_q + 2'd1;
							state_q <= S_TERM;
						end
					end
				end
				S_GRAD1: state_q <= S_GRAD2;
				S_GRAD2: state_q <= S_UPD1;
				S_UPD1:  state_q <= S_UPD2;
				S_UPD2:  state_q <= S_OUT;
				S_OUT: begin
					if (!out_valid_q || out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hdl/tv_denoise_gradient_step_core.sv */
// Top level of the TV denoise gradient step core: configuration registers and
// the controller and datapath instances. Depends on tvd_pkg, tvd_ctrl, tvd_datapath.
//
// The core takes estimate and observed pixels in raster order and, for each pixel,
// returns the ROF functional derivative (signed Q11.12) and the descent update
// (signed Q3.12), both saturated, with tuser marking the last pixel of the frame.
// Results lag the input by one row and one pixel, so a frame of W x H pixels must
// be followed by W+1 drain transfers (flush set, or any data); a flush inside the
// frame is discarded without moving the position. An input transfer that causes
// a result holds the core for longer the more of its one-sided differences stay
// inside the image (0 to 4): the window is fetched through the single read port
// of the line memory one pixel a cycle, and each difference passes in turn
// through one shared normalising unit with a bit-serial square root and division.
// A finished result waits in the output register while the next input is taken.
// Writing the width or height restarts the frame at its first pixel, but only
// while the controller waits for input; otherwise the position is kept.
module tv_denoise_gradient_step_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [31:0]                    s_axis_tdata,  // estimate, observed
	input  logic                           s_axis_tuser,  // flush
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [39:0]                    m_axis_tdata,  // gradient, updated_estimate
	output logic                           m_axis_tuser,  // frame_end
	input  logic                           cfg_we,
	input  logic [tvd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tvd_pkg::CFG_W-1:0]      cfg_data
);

	logic [15:0]                 lambda_q, step_q, smooth_q;
	logic [tvd_pkg::WREG_W-1:0]  width_q;
	logic [tvd_pkg::HREG_W-1:0]  height_q;
	logic [tvd_pkg::WREG_W-1:0]  eff_w;
	logic [tvd_pkg::HREG_W-1:0]  eff_h;
	logic                        restart;
	logic                        norm_done;
	tvd_pkg::tvd_cmd_t           cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_q <= 16'd256;
			step_q   <= 16'd66;
			smooth_q <= 16'd6554;
			width_q  <= 11'd1024;
			height_q <= 13'd1024;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tvd_pkg::REG_LAMBDA: lambda_q <= cfg_data;
				tvd_pkg::REG_STEP:   step_q   <= cfg_data;
				tvd_pkg::REG_SMOOTH: smooth_q <= cfg_data;
				tvd_pkg::REG_WIDTH:  width_q  <= cfg_data[tvd_pkg::WREG_W-1:0];
				tvd_pkg::REG_HEIGHT: height_q <= cfg_data[tvd_pkg::HREG_W-1:0];
				default: ;
			endcase
		end
	end

	// A geometry write sends the frame position back to its start if the controller is idle.
	assign restart = cfg_we && (cfg_index == tvd_pkg::REG_WIDTH
	                         || cfg_index == tvd_pkg::REG_HEIGHT);

	// The working geometry is the register value held within its legal range.
	assign eff_w = (width_q < 11'd2) ? 11'd2
	             : (width_q > 11'(tvd_pkg::MAX_WIDTH)) ? 11'(tvd_pkg::MAX_WIDTH) : width_q;
	assign eff_h = (height_q < 13'd2) ? 13'd2
	             : (height_q > 13'(tvd_pkg::MAX_HEIGHT)) ? 13'(tvd_pkg::MAX_HEIGHT)
	             : height_q;

	tvd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.eff_w     (eff_w),
		.eff_h     (eff_h),
		.in_valid  (s_axis_tvalid),
		.in_flush  (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.norm_done (norm_done),
		.out_valid (m_axis_tvalid),
		.out_last  (m_axis_tuser),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	tvd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_estimate (s_axis_tdata[15:0]),
		.in_observed (s_axis_tdata[31:16]),
		.lambda      (lambda_q),
		.step_size   (step_q),
		.smoothing   (smooth_q),
		.norm_done   (norm_done),
		.out_data    (m_axis_tdata)
	);

endmodule

/* hdl/tvd_checker.sv */
// Port-level checker of the TV denoise core and its bind to the top level.
// Depends on tv_denoise_gradient_step_core_assert.svh.
`include "tv_denoise_gradient_step_core_assert.svh"

module tvd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);

	`TVD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result withdrawn while stalled")
	`TVD_ASSERT_NEXT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "stalled result changed")
	`TVD_ASSERT_SAME(a_new_result_ready, clk, arst_n, $rose(m_axis_tvalid), s_axis_tready, "input not offered when a result is posted")
	`TVD_ASSERT_NEXT(a_no_instant_result, clk, arst_n, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result posted one cycle after input")

endmodule

bind tv_denoise_gradient_step_core tvd_checker u_chk (.*);

/* dv/tb_tv_denoise_gradient_step_core.sv */
// Self-checking testbench of the TV denoise gradient step core.
// Depends on tvd_pkg and tv_denoise_gradient_step_core; reads no files.
module tb_tv_denoise_gradient_step_core;
	timeunit 1ns;
	timeprecision 1ps;

	// One pixel transfer as offered on the input stream.
	typedef struct {
		logic signed [15:0] est;
		logic signed [15:0] obs;
		logic               flush;
	} pixel_t;

	// One result as the block must return it.
	typedef struct {
		logic signed [23:0] grad;
		logic signed [15:0] upd;
		logic               frame_end;
	} result_t;

	localparam int HOLD_OFF = 2000;   // long receiver stall, in cycles
	localparam int SETTLE   = 300;    // beyond the slowest result, in cycles
	localparam int LIMIT    = 4000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic                          cfg_we = 1'b0;
	logic [tvd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tvd_pkg::CFG_W-1:0]     cfg_data = '0;

	tv_denoise_gradient_step_core dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	pixel_t  pending_pixels[$];
	result_t expected_results[$];
	int      mismatches = 0;
	int      results_seen = 0;
	int      pixels_queued = 0;
	int      frames_done = 0;
	bit      quiet = 1'b0;    // no idling on either side while set
	bit      hold_req = 1'b0; // asks the receiver for one long stall

	// Mirror of the block: registers, line buffers and frame position.
	int unsigned lam_r, tau_r, beta_r, width_r, height_r;
	int          est_buf[4][tvd_pkg::MAX_WIDTH];
	int          obs_buf[2][tvd_pkg::MAX_WIDTH];
	int          row_pos, col_pos;

	function automatic longint minmod(input longint a, input longint b);
		longint ma, mb, mn;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		mn = ma <= mb ? ma : mb;
		if (a > 0 && b > 0) return mn;
		if (a < 0 && b < 0) return -mn;
		return 0;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Normalised difference a / sqrt(a^2 + b^2 + beta): inputs Q.13, result Q.16.
	function automatic longint norm_term(input longint a, input longint b);
		longint unsigned s, r, mag, q;
		s = longint'(a * a) + longint'(b * b) + (longint'(beta_r) << 10);
		r = int_sqrt(s << 12);
		mag = a < 0 ? -a : a;
		if (r == 0) return 0;
		q = ((mag << 23) / r + 1) >> 1;
		return a < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint clamp(input longint v, input int bits);
		longint hi;
		hi = (longint'(1) << (bits - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic int eff_width();
		if (width_r < 2) return 2;
		if (width_r > tvd_pkg::MAX_WIDTH) return tvd_pkg::MAX_WIDTH;
		return width_r;
	endfunction

	function automatic int eff_height();
		if (height_r < 2) return 2;
		if (height_r > tvd_pkg::MAX_HEIGHT) return tvd_pkg::MAX_HEIGHT;
		return height_r;
	endfunction

	// Takes one accepted pixel transfer into the mirror and queues the result
	// that it releases, which belongs to the pixel one row and one pixel back.
	task automatic predict_gradient_step(input pixel_t px);
		int w, h, t, k, r, c, lr, lc, rr, cc;
		longint win[9];
		longint p, vxp, vxm, vyp, vym, dv, g20, grad, upd;
		result_t res;
		w = eff_width();
		h = eff_height();
		t = row_pos * w + col_pos;
		if (row_pos < h) begin
			// A flush at a pixel position is dropped without moving on.
			if (px.flush) return;
			est_buf[row_pos & 3][col_pos] = px.est;
			obs_buf[row_pos & 1][col_pos] = px.obs;
		end
		if (t >= w + 1) begin
			k = t - w - 1;
			r = k / w;
			c = k % w;
			lr = h - 1;
			lc = w - 1;
			// Neighbours outside the image repeat the edge pixel.
			for (int dr = -1; dr <= 1; dr++)
				for (int dc = -1; dc <= 1; dc++) begin
					rr = r + dr;
					cc = c + dc;
					if (rr < 0) rr = 0;
					if (rr > lr) rr = lr;
					if (cc < 0) cc = 0;
					if (cc > lc) cc = lc;
					win[(dr + 1) * 3 + dc + 1] = est_buf[rr & 3][cc];
				end
			p = win[4];
			vxp = 0; vxm = 0; vyp = 0; vym = 0;
			// Differences that would cross the border contribute nothing.
			if (r < lr) vxp = norm_term(2 * (win[7] - p), minmod(win[8] - win[6], win[5] - win[3]));
			if (r > 0)  vxm = norm_term(2 * (p - win[1]), minmod(win[5] - win[3], win[2] - win[0]));
			if (c < lc) vyp = norm_term(2 * (win[5] - p), minmod(win[8] - win[2], win[7] - win[1]));
			if (c > 0)  vym = norm_term(2 * (p - win[3]), minmod(win[7] - win[1], win[6] - win[0]));
			dv = (vxp - vxm) + (vyp - vym);
			g20 = longint'(lam_r) * (p - obs_buf[r & 1][c]) - dv * 16;
			grad = clamp((g20 + 128) >>> 8, tvd_pkg::GRAD_W);
			upd = clamp((p * 65536 - longint'(tau_r) * grad + 32768) >>> 16, tvd_pkg::PIX_W);
			res.grad = grad[23:0];
			res.upd = upd[15:0];
			res.frame_end = (k == w * h - 1);
			expected_results.push_back(res);
		end
		col_pos++;
		if (row_pos < h) begin
			if (col_pos == w) begin
				col_pos = 0;
				row_pos++;
			end
		end else if (col_pos >= w + 1) begin
			col_pos = 0;
			row_pos = 0;
			frames_done++;
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Input side: takes the next pixel from the queue unless it idles this cycle.
	always @(posedge clk or negedge arst_n) begin
		pixel_t px;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predict_gradient_step('{s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tuser});
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_pixels.size() != 0 && (quiet || $urandom_range(0, 99) >= 26)) begin
					px = pending_pixels.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {px.obs, px.est};
					s_axis_tuser <= px.flush;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output side: checks every result transfer and throttles tready, with one
	// long stall on request so that the block backs up into its input.
	int hold_count = 0;
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", m_axis_tdata[23:0], 0);
				end else begin
					want = expected_results.pop_front();
					if (m_axis_tdata[23:0] !== want.grad)
						report_mismatch("gradient", $signed(m_axis_tdata[23:0]), want.grad);
					if (m_axis_tdata[39:24] !== want.upd)
						report_mismatch("updated estimate", $signed(m_axis_tdata[39:24]), want.upd);
					if (m_axis_tuser !== want.frame_end)
						report_mismatch("frame end", m_axis_tuser, want.frame_end);
				end
			end
			if (hold_count > 0) begin
				hold_count <= hold_count - 1;
				m_axis_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req <= 1'b0;
				hold_count <= HOLD_OFF;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= quiet || $urandom_range(0, 99) >= 26;
			end
		end
	end

	// Run guard.
	int cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_reg(input logic [tvd_pkg::CFG_IDX_W-1:0] idx, input int unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[15:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			tvd_pkg::REG_LAMBDA: lam_r = value & 16'hFFFF;
			tvd_pkg::REG_STEP:   tau_r = value & 16'hFFFF;
			tvd_pkg::REG_SMOOTH: beta_r = value & 16'hFFFF;
			tvd_pkg::REG_WIDTH: begin
				width_r = value & 11'h7FF;
				row_pos = 0;
				col_pos = 0;
			end
			tvd_pkg::REG_HEIGHT: begin
				height_r = value & 13'h1FFF;
				row_pos = 0;
				col_pos = 0;
			end
			default: ;
		endcase
	endtask

	// Waits until every queued pixel is taken and every result returned, then
	// lets a pixel that releases no result finish inside the block.
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_pixels.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic queue_pixel(input int est, input int obs, input bit flush);
		pending_pixels.push_back('{est[15:0], obs[15:0], flush});
		pixels_queued++;
	endtask

	// Pixel content by style: full-range noise, a smooth ramp with small
	// differences, a flat patch, or the two extreme codes.
	function automatic int pixel_value(input int style, input int base, input int x, input int y);
		case (style)
			0: return $urandom;
			1: return base + 37 * x - 23 * y + $urandom_range(0, 63) - 32;
			2: return base;
			default: return $urandom_range(0, 1) ? 32767 : -32768;
		endcase
	endfunction

	// Sends up to n_pix pixels of a frame (all of it if n_pix < 0), with stray
	// flushes among the pixels and, when drain is set, drain transfers, some carrying data.
	task automatic queue_frame(input int n_pix, input bit drain);
		int w, h, style, base, total;
		w = eff_width();
		h = eff_height();
		style = $urandom_range(0, 9) < 5 ? 1 : $urandom_range(0, 3);
		base = $urandom;
		total = (n_pix < 0) ? w * h : n_pix;
		for (int i = 0; i < total; i++) begin
			if ($urandom_range(0, 99) < 4) queue_pixel($urandom, $urandom, 1'b1);
			queue_pixel(pixel_value(style, base, i % w, i / w),
				pixel_value($urandom_range(0, 1) ? style : 0, base, i % w, i / w), 1'b0);
		end
		if (drain)
			for (int i = 0; i <= w; i++)
				if ($urandom_range(0, 9) < 2) queue_pixel($urandom, $urandom, 1'b0);
				else queue_pixel($urandom, $urandom, 1'b1);
	endtask

	function automatic int unsigned pick16();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 16'hFFFF;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	initial begin
		int phase;
		lam_r = 256; tau_r = 66; beta_r = 6554; width_r = 1024; height_r = 1024;
		foreach (est_buf[i, j]) est_buf[i][j] = 0;
		foreach (obs_buf[i, j]) obs_buf[i][j] = 0;
		row_pos = 0;
		col_pos = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: a flat 2x2 frame with no smoothing (zero root, zero minmod),
		// width and height below range so both saturate to two.
		write_reg(tvd_pkg::REG_SMOOTH, 0);
		write_reg(tvd_pkg::REG_WIDTH, 0);
		write_reg(tvd_pkg::REG_HEIGHT, 1);
		queue_pixel(1000, 900, 1'b0);
		queue_pixel(1000, 1200, 1'b1);      // flush at a pixel position
		queue_pixel(1000, -300, 1'b0);
		queue_pixel(1000, 0, 1'b0);
		queue_pixel(1000, 1000, 1'b0);
		queue_pixel(555, 555, 1'b0);        // data during drain
		queue_pixel(0, 0, 1'b1);
		queue_pixel(0, 0, 1'b1);
		wait_idle();
		// Directed: extreme codes with the largest weight and step, so that
		// both outputs saturate.
		write_reg(tvd_pkg::REG_LAMBDA, 16'hFFFF);
		write_reg(tvd_pkg::REG_STEP, 16'hFFFF);
		write_reg(tvd_pkg::REG_SMOOTH, 1);
		write_reg(tvd_pkg::REG_WIDTH, 3);
		write_reg(tvd_pkg::REG_HEIGHT, 2);
		queue_pixel(32767, -32768, 1'b0);
		queue_pixel(-32768, 32767, 1'b0);
		queue_pixel(32767, -32768, 1'b0);
		queue_pixel(-32768, 32767, 1'b0);
		queue_pixel(32767, -32768, 1'b0);
		queue_pixel(-32768, 32767, 1'b0);
		for (int i = 0; i < 4; i++) queue_pixel(0, 0, 1'b1);
		wait_idle();
		// Widest setting, over range: only the opening pixels, which release no
		// result, before the geometry is rewritten.
		write_reg(tvd_pkg::REG_WIDTH, 2047);
		write_reg(tvd_pkg::REG_HEIGHT, 8191);
		queue_frame(24, 1'b0);
		wait_idle();

		// Random phases with fresh settings each time; the fourth phase always
		// sends whole small frames under one long receiver stall.
		phase = 0;
		while (pixels_queued < 1900) begin
			quiet = (phase >= 6 && phase < 10);
			if ($urandom_range(0, 2) == 0) write_reg(tvd_pkg::REG_LAMBDA, pick16());
			if ($urandom_range(0, 2) == 0) write_reg(tvd_pkg::REG_STEP, pick16());
			if ($urandom_range(0, 2) == 0) write_reg(tvd_pkg::REG_SMOOTH, pick16());
			case ((phase == 3) ? 2 : $urandom_range(0, 19))
				0: begin
					write_reg(tvd_pkg::REG_WIDTH, 1024);
					write_reg(tvd_pkg::REG_HEIGHT, $urandom_range(2, 3));
					queue_frame($urandom_range(1, 40), 1'b0);
				end
				1: begin
					write_reg(tvd_pkg::REG_WIDTH, $urandom_range(2, 6));
					write_reg(tvd_pkg::REG_HEIGHT, 4096);
					queue_frame($urandom_range(10, 30), 1'b0);
				end
				default: begin
					write_reg(tvd_pkg::REG_WIDTH, $urandom_range(0, 9));
					write_reg(tvd_pkg::REG_HEIGHT, $urandom_range(0, 7));
					if (phase == 3) hold_req = 1'b1;
					queue_frame(-1, 1'b1);
					if ($urandom_range(0, 2) == 0) queue_frame(-1, 1'b1);
					if ($urandom_range(0, 4) == 0) queue_frame($urandom_range(1, 12), 1'b0);
				end
			endcase
			wait_idle();
			phase++;
		end

		$display("Covered %0d pixel transfers in %0d phases, %0d complete frames,",
			pixels_queued, phase + 3, frames_done);
		$display("%0d results checked, %0d mismatches.", results_seen, mismatches);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
